FILE: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define NRH_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nrh assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high
`define NRH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nrh assertion failed: next-cycle rule");

`endif

FILE: src/nrh_pkg.sv
// Shared constants, operation codes and command/status types for the ray hit block
`timescale 1ns / 1ps

package nrh_pkg;

   // Number format and field widths
   localparam int FRAC_BITS    = 12;
   localparam int UNIT_BITS    = 30;
   localparam int COORD_W      = 24;
   localparam int RAD_W        = 23;
   localparam int IDX_W        = 8;
   localparam int MAX_ENTITIES = 256;
   localparam int CNT_W        = $clog2(MAX_ENTITIES);
   localparam int M_LIMIT      = 1 << 29;
   localparam int MUL_W        = 34;
   localparam int DIV_N_W      = 64;
   localparam int DIV_D_W      = 32;
   localparam int DIST_W       = 48;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_ORG_X = 3'd0;
   localparam logic [2:0] CSR_ORG_Y = 3'd1;
   localparam logic [2:0] CSR_ORG_Z = 3'd2;
   localparam logic [2:0] CSR_DIR_X = 3'd3;
   localparam logic [2:0] CSR_DIR_Y = 3'd4;
   localparam logic [2:0] CSR_DIR_Z = 3'd5;

   // Datapath operations
   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_LOAD   = 5'd1;
   localparam logic [4:0] OP_DIV_M  = 5'd2;
   localparam logic [4:0] OP_WR_M   = 5'd3;
   localparam logic [4:0] OP_DIV_N  = 5'd4;
   localparam logic [4:0] OP_WR_N   = 5'd5;
   localparam logic [4:0] OP_NORM   = 5'd6;
   localparam logic [4:0] OP_MUL    = 5'd7;
   localparam logic [4:0] OP_ACC    = 5'd8;
   localparam logic [4:0] OP_SQRT_A = 5'd9;
   localparam logic [4:0] OP_WR_LEN = 5'd10;
   localparam logic [4:0] OP_DIV_U  = 5'd11;
   localparam logic [4:0] OP_WR_U   = 5'd12;
   localparam logic [4:0] OP_WR_B   = 5'd13;
   localparam logic [4:0] OP_WR_C   = 5'd14;
   localparam logic [4:0] OP_WR_D   = 5'd15;
   localparam logic [4:0] OP_SQRT_D = 5'd16;
   localparam logic [4:0] OP_WR_T   = 5'd17;
   localparam logic [4:0] OP_WR_W   = 5'd18;
   localparam logic [4:0] OP_WR_HIT = 5'd19;
   localparam logic [4:0] OP_UPD    = 5'd20;
   localparam logic [4:0] OP_CNT    = 5'd21;
   localparam logic [4:0] OP_EMIT   = 5'd22;

   // Multiplier operand pairs
   localparam logic [2:0] SEL_NN = 3'd0;
   localparam logic [2:0] SEL_MU = 3'd1;
   localparam logic [2:0] SEL_MM = 3'd2;
   localparam logic [2:0] SEL_BB = 3'd3;
   localparam logic [2:0] SEL_TU = 3'd4;
   localparam logic [2:0] SEL_WR = 3'd5;
   localparam logic [2:0] SEL_DF = 3'd6;

   typedef struct packed {
      logic [4:0] op;
      logic [2:0] sel;
      logic [1:0] ax;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic mx_zero;
      logic norm_ok;
      logic away;
      logic discr_neg;
      logic shootable;
      logic last;
      logic out_free;
   } stat_type;

endpackage

FILE: src/nearest_ray_ellipsoid_hit_top.sv
// Top level: nearest ray/ellipsoid hit over a stream of entities
//
//   Channel   Direction  Handshake            Moves
//   req_      in         req_valid/req_ready  one entity per transaction
//   rsp_      out        rsp_valid/rsp_ready  one query result per transaction
//   csr_      in         csr_wr_en            ray register write, no wait
//
// Non-shootable entity: counted and skipped. Shootable: tested to the end or rejected early;
// the full test runs nine divides on the shared radix-2 divider, two square roots and a
// normalize of up to 33 one-bit shifts.
// A last entity then also loads the result register; that step waits while an
// earlier result is still held there, and no entity is taken meanwhile.
// Reset is synchronous and restores the ray registers and clears the query state.
`timescale 1ns / 1ps

module nearest_ray_ellipsoid_hit_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_center_x,
   input  logic signed [23:0] req_center_y,
   input  logic signed [23:0] req_center_z,
   input  logic [22:0]        req_radius_xz,
   input  logic [22:0]        req_radius_up,
   input  logic               req_shootable,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_any_hit,
   output logic signed [23:0] rsp_hit_x,
   output logic signed [23:0] rsp_hit_y,
   output logic signed [23:0] rsp_hit_z,
   output logic [7:0]         rsp_entity_index
);

   nrh_pkg::cmd_type  cmd;
   nrh_pkg::stat_type stat;

   nrh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nrh_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .req_radius_xz    (req_radius_xz),
      .req_radius_up    (req_radius_up),
      .req_shootable    (req_shootable),
      .req_last         (req_last),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_any_hit      (rsp_any_hit),
      .rsp_hit_x        (rsp_hit_x),
      .rsp_hit_y        (rsp_hit_y),
      .rsp_hit_z        (rsp_hit_z),
      .rsp_entity_index (rsp_entity_index)
   );

endmodule

FILE: src/nrh_div.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
`timescale 1ns / 1ps

module nrh_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [nrh_pkg::DIV_N_W-1:0]       dividend,
   input  logic [nrh_pkg::DIV_D_W-1:0]       divisor,
   output logic                              busy,
   output logic [nrh_pkg::DIV_N_W-1:0]       quotient
);

   localparam int CW = $clog2(nrh_pkg::DIV_N_W + 1);

   logic                            busy_ff;
   logic [CW-1:0]                   cnt_ff;
   logic [nrh_pkg::DIV_D_W-1:0]     rem_ff;
   logic [nrh_pkg::DIV_N_W-1:0]     quo_ff;
   logic [nrh_pkg::DIV_D_W-1:0]     dvs_ff;
   logic [nrh_pkg::DIV_D_W:0]       trial;
   logic                            ge;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[nrh_pkg::DIV_N_W-1]};
      ge    = (trial >= {1'b0, dvs_ff});
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(nrh_pkg::DIV_N_W);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CW'(1));
      end
   end

   // Partial remainder and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? nrh_pkg::DIV_D_W'(trial - {1'b0, dvs_ff})
                      : trial[nrh_pkg::DIV_D_W-1:0];
         quo_ff <= {quo_ff[nrh_pkg::DIV_N_W-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/nrh_sqrt.sv
// Bit-pair integer square root of a 64-bit value, one result bit per cycle
`timescale 1ns / 1ps

module nrh_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] val,
   output logic        busy,
   output logic [31:0] root
);

   logic        busy_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [64:0] trial;
   logic        ge;

   always_comb begin
      trial = {1'b0, res_ff} + {1'b0, bit_ff};
      ge    = ({1'b0, x_ff} >= trial);
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 6'd32;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != 6'd1);
      end
   end

   // Remainder, partial root and probe bit
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= val;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (ge) begin
            x_ff   <= 64'(({1'b0, x_ff}) - trial);
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule

FILE: src/nrh_dpath.sv
// Datapath: ray registers, per-entity working registers, shared multiplier, divider, root
`timescale 1ns / 1ps

module nrh_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [2:0]                     csr_index,
   input  logic [23:0]                    csr_wdata,
   input  logic signed [23:0]             req_center_x,
   input  logic signed [23:0]             req_center_y,
   input  logic signed [23:0]             req_center_z,
   input  logic [22:0]                    req_radius_xz,
   input  logic [22:0]                    req_radius_up,
   input  logic                           req_shootable,
   input  logic                           req_last,
   input  nrh_pkg::cmd_type               cmd,
   output nrh_pkg::stat_type              stat,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_any_hit,
   output logic signed [23:0]             rsp_hit_x,
   output logic signed [23:0]             rsp_hit_y,
   output logic signed [23:0]             rsp_hit_z,
   output logic [7:0]                     rsp_entity_index
);

   localparam int F  = nrh_pkg::FRAC_BITS;
   localparam int U  = nrh_pkg::UNIT_BITS;
   localparam int MW = nrh_pkg::MUL_W;

   // Ray registers
   logic signed [23:0] org_ff [3];
   logic signed [23:0] dir_ff [3];

   // Current entity
   logic signed [24:0] ctr_ff [3];
   logic [22:0]        rad_xz_ff;
   logic [22:0]        rad_up_ff;
   logic               shoot_ff;
   logic               last_ff;

   // Working registers
   logic signed [30:0] m_ff [3];
   logic [62:0]        n_ff [3];
   logic [62:0]        mx_ff;
   logic signed [31:0] u_ff [3];
   logic [31:0]        len_ff;
   logic signed [63:0] acc_ff;
   logic signed [67:0] prod_ff;
   logic signed [33:0] b_ff;
   logic signed [63:0] c_ff;
   logic signed [63:0] discr_ff;
   logic signed [33:0] t_ff;
   logic signed [33:0] w_ff;
   logic signed [23:0] hit_ff [3];

   // Query state
   logic [nrh_pkg::DIST_W-1:0] best_dist_ff;
   logic signed [23:0]         best_pos_ff [3];
   logic [nrh_pkg::IDX_W-1:0]  best_idx_ff;
   logic                       found_ff;
   logic [nrh_pkg::CNT_W-1:0]  cnt_ff;

   // Output register
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic signed [23:0] rsp_pos_ff [3];
   logic [7:0]         rsp_idx_ff;

   // Shared units
   logic                          div_start;
   logic [nrh_pkg::DIV_N_W-1:0]   div_dvd;
   logic [nrh_pkg::DIV_D_W-1:0]   div_dvs;
   logic                          div_busy;
   logic [nrh_pkg::DIV_N_W-1:0]   div_quo;
   logic                          sq_start;
   logic [63:0]                   sq_val;
   logic                          sq_busy;
   logic [31:0]                   sq_root;

   // Per-axis selections
   logic [22:0]        rad_ax;
   logic signed [25:0] rel_ax;
   logic [24:0]        rel_mag;
   logic [23:0]        dir_mag;
   logic signed [24:0] df_ax;
   logic signed [MW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic signed [67:0] prod_in;
   logic [29:0]        m_q;
   logic signed [31:0] u_q;
   logic signed [34:0] t_calc;
   logic signed [55:0] off_ax;
   logic signed [56:0] hit_sum;
   logic signed [23:0] hit_sat;
   logic [nrh_pkg::DIST_W-1:0] dist_sat;
   logic               out_free;

   always_comb begin
      rad_ax  = (cmd.ax == 2'd1) ? rad_up_ff : rad_xz_ff;
      rel_ax  = 26'(org_ff[cmd.ax]) - 26'(ctr_ff[cmd.ax]);
      rel_mag = rel_ax[25] ? 25'(-rel_ax) : rel_ax[24:0];
      dir_mag = dir_ff[cmd.ax][23] ? 24'(-25'(dir_ff[cmd.ax])) : dir_ff[cmd.ax];
      df_ax   = 25'(hit_ff[cmd.ax]) - 25'(org_ff[cmd.ax]);
   end

   // Divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = {9'b0, rad_ax};
      case (cmd.op)
         nrh_pkg::OP_DIV_M: begin
            div_start = 1'b1;
            div_dvd   = {27'b0, rel_mag, F'(0)};
         end
         nrh_pkg::OP_DIV_N: begin
            div_start = 1'b1;
            div_dvd   = {1'b0, dir_mag, 39'b0};
         end
         nrh_pkg::OP_DIV_U: begin
            div_start = 1'b1;
            div_dvd   = {4'b0, n_ff[cmd.ax][29:0], U'(0)};
            div_dvs   = len_ff;
         end
         default: ;
      endcase
   end

   // Square root operand selection
   always_comb begin
      sq_start = (cmd.op == nrh_pkg::OP_SQRT_A) || (cmd.op == nrh_pkg::OP_SQRT_D);
      sq_val   = (cmd.op == nrh_pkg::OP_SQRT_D) ? discr_ff : acc_ff;
   end

   nrh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   nrh_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .val   (sq_val),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   // Multiplier operand selection
   always_comb begin
      case (cmd.sel)
         nrh_pkg::SEL_NN: begin
            mul_a = MW'(signed'({1'b0, n_ff[cmd.ax][29:0]}));
            mul_b = mul_a;
         end
         nrh_pkg::SEL_MU: begin
            mul_a = MW'(m_ff[cmd.ax]);
            mul_b = MW'(u_ff[cmd.ax]);
         end
         nrh_pkg::SEL_MM: begin
            mul_a = MW'(m_ff[cmd.ax]);
            mul_b = mul_a;
         end
         nrh_pkg::SEL_BB: begin
            mul_a = b_ff;
            mul_b = b_ff;
         end
         nrh_pkg::SEL_TU: begin
            mul_a = t_ff;
            mul_b = MW'(u_ff[cmd.ax]);
         end
         nrh_pkg::SEL_WR: begin
            mul_a = w_ff;
            mul_b = MW'(signed'({1'b0, rad_ax}));
         end
         nrh_pkg::SEL_DF: begin
            mul_a = MW'(df_ax);
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // Result shaping of the single-step writes
   always_comb begin
      m_q     = (div_quo > 64'(nrh_pkg::M_LIMIT)) ? 30'(nrh_pkg::M_LIMIT) : div_quo[29:0];
      u_q     = signed'({1'b0, div_quo[30:0]});
      t_calc  = -35'(b_ff) - signed'({3'b0, sq_root});
      off_ax  = prod_ff[67:F];
      hit_sum = 57'(org_ff[cmd.ax]) + 57'(off_ax);
      if (hit_sum > 57'sd8388607) begin
         hit_sat = 24'sh7FFFFF;
      end else if (hit_sum < -57'sd8388608) begin
         hit_sat = 24'sh800000;
      end else begin
         hit_sat = hit_sum[23:0];
      end
      dist_sat = (acc_ff[63:nrh_pkg::DIST_W] != '0) ? '1 : acc_ff[nrh_pkg::DIST_W-1:0];
   end

   // Ray registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= 24'(1 << F);
         dir_ff[1] <= '0;
         dir_ff[2] <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            nrh_pkg::CSR_ORG_X: org_ff[0] <= csr_wdata;
            nrh_pkg::CSR_ORG_Y: org_ff[1] <= csr_wdata;
            nrh_pkg::CSR_ORG_Z: org_ff[2] <= csr_wdata;
            nrh_pkg::CSR_DIR_X: dir_ff[0] <= csr_wdata;
            nrh_pkg::CSR_DIR_Y: dir_ff[1] <= csr_wdata;
            nrh_pkg::CSR_DIR_Z: dir_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Working registers, one operation per cycle
   always_ff @(posedge clock) begin
      case (cmd.op)
         nrh_pkg::OP_LOAD: begin
            ctr_ff[0] <= 25'(req_center_x);
            ctr_ff[1] <= 25'(req_center_y) + 25'(1 << (F - 1));
            ctr_ff[2] <= 25'(req_center_z);
            rad_xz_ff <= (req_radius_xz == '0) ? 23'd1 : req_radius_xz;
            rad_up_ff <= (req_radius_up == '0) ? 23'd1 : req_radius_up;
            shoot_ff  <= req_shootable;
            last_ff   <= req_last;
            acc_ff    <= '0;
            mx_ff     <= '0;
         end
         nrh_pkg::OP_WR_M: m_ff[cmd.ax] <= rel_ax[25] ? -signed'({1'b0, m_q})
                                                       : signed'({1'b0, m_q});
         nrh_pkg::OP_WR_N: begin
            n_ff[cmd.ax] <= div_quo[62:0];
            if (div_quo[62:0] > mx_ff) begin
               mx_ff <= div_quo[62:0];
            end
         end
         nrh_pkg::OP_NORM: begin
            if (mx_ff[62:30] != '0) begin
               mx_ff   <= mx_ff >> 1;
               n_ff[0] <= n_ff[0] >> 1;
               n_ff[1] <= n_ff[1] >> 1;
               n_ff[2] <= n_ff[2] >> 1;
            end else if (!mx_ff[29]) begin
               mx_ff   <= mx_ff << 1;
               n_ff[0] <= n_ff[0] << 1;
               n_ff[1] <= n_ff[1] << 1;
               n_ff[2] <= n_ff[2] << 1;
            end
         end
         nrh_pkg::OP_MUL:    prod_ff <= prod_in;
         nrh_pkg::OP_ACC:    acc_ff  <= acc_ff + prod_ff[63:0];
         nrh_pkg::OP_SQRT_A: acc_ff  <= '0;
         nrh_pkg::OP_WR_LEN: len_ff  <= sq_root;
         nrh_pkg::OP_WR_U:   u_ff[cmd.ax] <= dir_ff[cmd.ax][23] ? -u_q : u_q;
         nrh_pkg::OP_WR_B: begin
            b_ff   <= acc_ff[63:U];
            acc_ff <= '0;
         end
         nrh_pkg::OP_WR_C: begin
            c_ff   <= acc_ff - 64'sd1 * (64'sd1 <<< (2 * F));
            acc_ff <= '0;
         end
         nrh_pkg::OP_WR_D:   discr_ff <= prod_ff[63:0] - c_ff;
         nrh_pkg::OP_WR_T:   t_ff <= t_calc[34] ? '0 : t_calc[33:0];
         nrh_pkg::OP_WR_W:   w_ff <= prod_ff[63:U];
         nrh_pkg::OP_WR_HIT: hit_ff[cmd.ax] <= hit_sat;
         default: ;
      endcase
   end

   // Nearest-hit tracking and item counter
   always_ff @(posedge clock) begin
      if (reset || (cmd.op == nrh_pkg::OP_EMIT)) begin
         best_dist_ff   <= '1;
         best_pos_ff[0] <= '0;
         best_pos_ff[1] <= '0;
         best_pos_ff[2] <= '0;
         best_idx_ff    <= '0;
         found_ff       <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         if ((cmd.op == nrh_pkg::OP_UPD) && (!found_ff || (dist_sat < best_dist_ff))) begin
            best_dist_ff <= dist_sat;
            best_pos_ff  <= hit_ff;
            best_idx_ff  <= nrh_pkg::IDX_W'(cnt_ff);
            found_ff     <= 1'b1;
         end
         if (cmd.op == nrh_pkg::OP_CNT) begin
            cnt_ff <= (cnt_ff == nrh_pkg::CNT_W'(nrh_pkg::MAX_ENTITIES - 1)) ? '0
                                                                             : cnt_ff + 1'b1;
         end
      end
   end

   // Output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == nrh_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == nrh_pkg::OP_EMIT) begin
         rsp_hit_ff <= found_ff;
         rsp_pos_ff <= best_pos_ff;
         rsp_idx_ff <= best_idx_ff;
      end
   end

   // Status to the controller
   always_comb begin
      stat.div_busy  = div_busy;
      stat.sqrt_busy = sq_busy;
      stat.mx_zero   = (mx_ff == '0);
      stat.norm_ok   = (mx_ff[62:30] == '0) && mx_ff[29];
      stat.away      = !c_ff[63] && (c_ff != '0) && !b_ff[33] && (b_ff != '0);
      stat.discr_neg = discr_ff[63];
      stat.shootable = shoot_ff;
      stat.last      = last_ff;
      stat.out_free  = out_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_any_hit      = rsp_hit_ff;
   assign rsp_hit_x        = rsp_pos_ff[0];
   assign rsp_hit_y        = rsp_pos_ff[1];
   assign rsp_hit_z        = rsp_pos_ff[2];
   assign rsp_entity_index = rsp_idx_ff;

endmodule

FILE: src/nrh_ctrl.sv
// Controller: sequences the datapath through one entity test and the query result
`timescale 1ns / 1ps

module nrh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  nrh_pkg::stat_type  stat,
   output nrh_pkg::cmd_type   cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_MDIV  = 5'd1;
   localparam logic [4:0] S_MWAIT = 5'd2;
   localparam logic [4:0] S_NDIV  = 5'd3;
   localparam logic [4:0] S_NWAIT = 5'd4;
   localparam logic [4:0] S_NCHK  = 5'd5;
   localparam logic [4:0] S_NORM  = 5'd6;
   localparam logic [4:0] S_MUL   = 5'd7;
   localparam logic [4:0] S_ACC   = 5'd8;
   localparam logic [4:0] S_SQST  = 5'd9;
   localparam logic [4:0] S_LWAIT = 5'd10;
   localparam logic [4:0] S_UDIV  = 5'd11;
   localparam logic [4:0] S_UWAIT = 5'd12;
   localparam logic [4:0] S_WRB   = 5'd13;
   localparam logic [4:0] S_WRC   = 5'd14;
   localparam logic [4:0] S_REJ   = 5'd15;
   localparam logic [4:0] S_WRD   = 5'd16;
   localparam logic [4:0] S_DCHK  = 5'd17;
   localparam logic [4:0] S_TWAIT = 5'd18;
   localparam logic [4:0] S_TU    = 5'd19;
   localparam logic [4:0] S_WRW   = 5'd20;
   localparam logic [4:0] S_WR    = 5'd21;
   localparam logic [4:0] S_HIT   = 5'd22;
   localparam logic [4:0] S_UPD   = 5'd23;
   localparam logic [4:0] S_NEXT  = 5'd24;
   localparam logic [4:0] S_EMIT  = 5'd25;

   logic [4:0] state_ff, state_in;
   logic [1:0] ax_ff, ax_in;
   logic [2:0] phase_ff, phase_in;

   // Next state and command
   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      phase_in  = phase_ff;
      cmd.op    = nrh_pkg::OP_NONE;
      cmd.sel   = phase_ff;
      cmd.ax    = ax_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = nrh_pkg::OP_LOAD;
               ax_in    = 2'd0;
               state_in = S_NEXT;
            end
         end
         S_MDIV: begin
            cmd.op   = nrh_pkg::OP_DIV_M;
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (!stat.div_busy) begin
               cmd.op = nrh_pkg::OP_WR_M;
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = S_NDIV;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_MDIV;
               end
            end
         end
         S_NDIV: begin
            cmd.op   = nrh_pkg::OP_DIV_N;
            state_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (!stat.div_busy) begin
               cmd.op = nrh_pkg::OP_WR_N;
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = S_NCHK;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_NDIV;
               end
            end
         end
         S_NCHK: begin
            state_in = stat.mx_zero ? S_NEXT : S_NORM;
         end
         S_NORM: begin
            if (stat.norm_ok) begin
               ax_in    = 2'd0;
               phase_in = nrh_pkg::SEL_NN;
               state_in = S_MUL;
            end else begin
               cmd.op = nrh_pkg::OP_NORM;
            end
         end
         S_MUL: begin
            cmd.op   = nrh_pkg::OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = nrh_pkg::OP_ACC;
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0;
               case (phase_ff)
                  nrh_pkg::SEL_NN: state_in = S_SQST;
                  nrh_pkg::SEL_MU: state_in = S_WRB;
                  nrh_pkg::SEL_MM: state_in = S_WRC;
                  default:         state_in = S_UPD;
               endcase
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_SQST: begin
            cmd.op   = nrh_pkg::OP_SQRT_A;
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            if (!stat.sqrt_busy) begin
               cmd.op   = nrh_pkg::OP_WR_LEN;
               ax_in    = 2'd0;
               state_in = S_UDIV;
            end
         end
         S_UDIV: begin
            cmd.op   = nrh_pkg::OP_DIV_U;
            state_in = S_UWAIT;
         end
         S_UWAIT: begin
            if (!stat.div_busy) begin
               cmd.op = nrh_pkg::OP_WR_U;
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  phase_in = nrh_pkg::SEL_MU;
                  state_in = S_MUL;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_UDIV;
               end
            end
         end
         S_WRB: begin
            cmd.op   = nrh_pkg::OP_WR_B;
            phase_in = nrh_pkg::SEL_MM;
            state_in = S_MUL;
         end
         S_WRC: begin
            cmd.op   = nrh_pkg::OP_WR_C;
            state_in = S_REJ;
         end
         S_REJ: begin
            if (stat.away) begin
               state_in = S_NEXT;
            end else begin
               cmd.op   = nrh_pkg::OP_MUL;
               cmd.sel  = nrh_pkg::SEL_BB;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            cmd.op   = nrh_pkg::OP_WR_D;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (stat.discr_neg) begin
               state_in = S_NEXT;
            end else begin
               cmd.op   = nrh_pkg::OP_SQRT_D;
               state_in = S_TWAIT;
            end
         end
         S_TWAIT: begin
            if (!stat.sqrt_busy) begin
               cmd.op   = nrh_pkg::OP_WR_T;
               ax_in    = 2'd0;
               state_in = S_TU;
            end
         end
         S_TU: begin
            cmd.op   = nrh_pkg::OP_MUL;
            cmd.sel  = nrh_pkg::SEL_TU;
            state_in = S_WRW;
         end
         S_WRW: begin
            cmd.op   = nrh_pkg::OP_WR_W;
            state_in = S_WR;
         end
         S_WR: begin
            cmd.op   = nrh_pkg::OP_MUL;
            cmd.sel  = nrh_pkg::SEL_WR;
            state_in = S_HIT;
         end
         S_HIT: begin
            cmd.op = nrh_pkg::OP_WR_HIT;
            if (ax_ff == 2'd2) begin
               ax_in    = 2'd0;
               phase_in = nrh_pkg::SEL_DF;
               state_in = S_MUL;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_TU;
            end
         end
         S_UPD: begin
            cmd.op   = nrh_pkg::OP_UPD;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            // first visit after the load decides whether the entity is tested
            if (stat.shootable && (phase_ff != nrh_pkg::SEL_MU) && (ax_ff == 2'd0)
                && (phase_ff == nrh_pkg::SEL_BB)) begin
               state_in = S_MDIV;
            end else begin
               cmd.op   = nrh_pkg::OP_CNT;
               phase_in = nrh_pkg::SEL_NN;
               state_in = stat.last ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = nrh_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // after a load, mark the pending test so the first visit to the count
      // state branches into the entity test if the entity is shootable
      if ((state_ff == S_IDLE) && req_valid) begin
         phase_in = nrh_pkg::SEL_BB;
      end
      if (state_ff == S_MDIV) begin
         phase_in = nrh_pkg::SEL_NN;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= 2'd0;
         phase_ff <= nrh_pkg::SEL_NN;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: src/nrh_checker.sv
// Port-level checker for the ray hit block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nrh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_any_hit,
   input logic [23:0] rsp_hit_x,
   input logic [23:0] rsp_hit_y,
   input logic [23:0] rsp_hit_z,
   input logic [7:0]  rsp_entity_index
);

   // One entity in flight: ready falls right after a transaction
   `NRH_ASSERT_NEXT(a_ready_drops, req_valid && req_ready, !req_ready)

   // Only a last entity can produce a result
   `NRH_ASSERT_NEXT(a_no_rsp_mid_query, req_valid && req_ready && !req_last, !$rose(rsp_valid))

   // A miss reports all-zero fields
   `NRH_ASSERT_SAME(a_miss_zero, rsp_valid && !rsp_any_hit, (rsp_hit_x == 24'd0) && (rsp_hit_y == 24'd0) && (rsp_hit_z == 24'd0) && (rsp_entity_index == 8'd0))

   // A stalled result holds
   `NRH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit_x) && $stable(rsp_entity_index))

endmodule

bind nearest_ray_ellipsoid_hit_top nrh_checker u_nrh_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the nearest ray/ellipsoid hit block
`timescale 1ns / 1ps

module tb;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam int     DRAIN_CYCLES = 1000;   // longer than one shootable entity
   localparam int     RANDOM_ITEMS = 1200;
   localparam int     QUIET_FROM   = 1050;   // no idling from here on
   localparam int     HOLD_AT      = 400;
   localparam int     HOLD_CYCLES  = 8000;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam longint ONE = 4096;
   localparam longint HALF = 2048;

   typedef struct {
      logic signed [23:0] cx, cy, cz;
      logic [22:0]        rxz, rup;
      logic               shoot, last;
   } entity_type;

   typedef struct {
      logic               any_hit;
      logic signed [23:0] hx, hy, hz;
      logic [7:0]         idx;
   } query_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [22:0]        req_radius_xz = '0, req_radius_up = '0;
   logic               req_shootable = 1'b0, req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_any_hit;
   logic signed [23:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic [7:0]         rsp_entity_index;

   nearest_ray_ellipsoid_hit_top dut (.*);

   function automatic longint clip24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // Bit-exact predictor of the nearest hit plus the queue of pending query results
   class hit_scoreboard;
      longint org[3], dir[3];
      bit [47:0] best_d;
      longint best_p[3];
      bit [7:0] best_i;
      bit found;
      int unsigned cnt;
      query_result_type pending[$];
      int errors;

      function void clear_query();
         best_d = '1;
         best_p = '{0, 0, 0};
         best_i = 0;
         found = 0;
         cnt = 0;
      endfunction

      function void reset_ray();
         org = '{0, 0, 0};
         dir = '{ONE, 0, 0};
         clear_query();
      endfunction

      function void write_reg(input logic [2:0] idx, input logic signed [23:0] v);
         case (idx)
            nrh_pkg::CSR_ORG_X: org[0] = v;
            nrh_pkg::CSR_ORG_Y: org[1] = v;
            nrh_pkg::CSR_ORG_Z: org[2] = v;
            nrh_pkg::CSR_DIR_X: dir[0] = v;
            nrh_pkg::CSR_DIR_Y: dir[1] = v;
            nrh_pkg::CSR_DIR_Z: dir[2] = v;
            default: ;
         endcase
      endfunction

      function bit [63:0] sqrt_floor(input bit [63:0] x);
         bit [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function bit [63:0] mag(input longint v);
         return (v < 0) ? -v : v;
      endfunction

      // Unit-sphere intersection of the ray with one ellipsoid
      function bit trace(input longint ctr[3], input longint rad[3], output longint hit[3]);
         longint m[3], u[3], acc, b, c, discr, t, w, off;
         bit [63:0] n[3], mx, q, len;
         mx = 0;
         hit = '{0, 0, 0};
         for (int i = 0; i < 3; i++) begin
            q = (mag(org[i] - ctr[i]) << nrh_pkg::FRAC_BITS) / rad[i];
            if (q > 64'(nrh_pkg::M_LIMIT)) q = nrh_pkg::M_LIMIT;
            m[i] = (org[i] - ctr[i] < 0) ? -longint'(q) : longint'(q);
            n[i] = (mag(dir[i]) << 39) / rad[i];
            if (n[i] > mx) mx = n[i];
         end
         if (mx == 0) return 0;
         while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) n[i] >>= 1;
         end
         while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) n[i] <<= 1;
         end
         len = sqrt_floor(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
         if (len == 0) return 0;
         for (int i = 0; i < 3; i++) begin
            q = (n[i] << nrh_pkg::UNIT_BITS) / len;
            u[i] = (dir[i] < 0) ? -longint'(q) : longint'(q);
         end
         acc = m[0] * u[0] + m[1] * u[1] + m[2] * u[2];
         b = acc >>> nrh_pkg::UNIT_BITS;
         c = m[0] * m[0] + m[1] * m[1] + m[2] * m[2]
             - (longint'(1) << (2 * nrh_pkg::FRAC_BITS));
         // starts outside and points away
         if (c > 0 && b > 0) return 0;
         discr = b * b - c;
         if (discr < 0) return 0;
         t = -b - longint'(sqrt_floor(discr));
         if (t < 0) t = 0;   // starts inside
         for (int i = 0; i < 3; i++) begin
            w = (t * u[i]) >>> nrh_pkg::UNIT_BITS;
            off = (w * rad[i]) >>> nrh_pkg::FRAC_BITS;
            hit[i] = clip24(org[i] + off);
         end
         return 1;
      endfunction

      function void note_entity(input entity_type e);
         longint ctr[3], rad[3], hit[3], df;
         bit [63:0] d;
         query_result_type r;
         if (e.shoot) begin
            ctr = '{longint'(e.cx), longint'(e.cy) + HALF, longint'(e.cz)};
            rad[0] = (e.rxz == 0) ? 1 : e.rxz;
            rad[1] = (e.rup == 0) ? 1 : e.rup;
            rad[2] = rad[0];
            if (trace(ctr, rad, hit)) begin
               d = 0;
               for (int i = 0; i < 3; i++) begin
                  df = hit[i] - org[i];
                  d += df * df;
               end
               if (d > 64'hFFFF_FFFF_FFFF) d = 64'hFFFF_FFFF_FFFF;
               // ties keep the earlier entity
               if (!found || d < best_d) begin
                  best_d = d;
                  best_p = hit;
                  best_i = cnt[7:0];
                  found = 1;
               end
            end
         end
         cnt = (cnt + 1 >= nrh_pkg::MAX_ENTITIES) ? 0 : cnt + 1;
         if (e.last) begin
            r.any_hit = found;
            r.hx = found ? best_p[0] : 0;
            r.hy = found ? best_p[1] : 0;
            r.hz = found ? best_p[2] : 0;
            r.idx = found ? best_i : 0;
            pending.insert(pending.size(), r);
            clear_query();
         end
      endfunction

      function void check_result(input query_result_type a);
         query_result_type x;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected (any_hit %0d)", $time, a.any_hit);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (a.any_hit !== x.any_hit) begin
            $display("%0t: any_hit exp %0d act %0d", $time, x.any_hit, a.any_hit);
            errors++;
         end
         if (a.hx !== x.hx) begin
            $display("%0t: hit_x exp %0d act %0d", $time, x.hx, a.hx);
            errors++;
         end
         if (a.hy !== x.hy) begin
            $display("%0t: hit_y exp %0d act %0d", $time, x.hy, a.hy);
            errors++;
         end
         if (a.hz !== x.hz) begin
            $display("%0t: hit_z exp %0d act %0d", $time, x.hz, a.hz);
            errors++;
         end
         if (a.idx !== x.idx) begin
            $display("%0t: entity_index exp %0d act %0d", $time, x.idx, a.idx);
            errors++;
         end
      endfunction
   endclass

   hit_scoreboard sb = new;
   bit quiet = 0;
   bit hold_start = 0;
   longint cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: check each transaction, stall in bursts, one long hold-off
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_any_hit, rsp_hit_x, rsp_hit_y, rsp_hit_z, rsp_entity_index});
         if (hold_start && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input longint v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[23:0];
      @(posedge clock);
      sb.write_reg(idx, v[23:0]);
   endtask

   task automatic set_ray(input longint o[3], input longint d[3]);
      write_reg(nrh_pkg::CSR_ORG_X, o[0]);
      write_reg(nrh_pkg::CSR_ORG_Y, o[1]);
      write_reg(nrh_pkg::CSR_ORG_Z, o[2]);
      write_reg(nrh_pkg::CSR_DIR_X, d[0]);
      write_reg(nrh_pkg::CSR_DIR_Y, d[1]);
      write_reg(nrh_pkg::CSR_DIR_Z, d[2]);
      write_reg(CSR_UNUSED, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // Hold the transaction until accepted, then maybe idle
   task automatic send_entity(input entity_type e);
      req_valid <= 1'b1;
      req_center_x <= e.cx;
      req_center_y <= e.cy;
      req_center_z <= e.cz;
      req_radius_xz <= e.rxz;
      req_radius_up <= e.rup;
      req_shootable <= e.shoot;
      req_last <= e.last;
      do @(posedge clock); while (!req_ready);
      sb.note_entity(e);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Block is idle: nothing pending and the last entity has had time to finish
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic entity_type mk(input longint x, y, z, input longint rxz, rup,
                                     input bit shoot, last);
      entity_type e;
      e.cx = x; e.cy = y; e.cz = z;
      e.rxz = rxz; e.rup = rup;
      e.shoot = shoot; e.last = last;
      return e;
   endfunction

   function automatic longint srand(input int unsigned span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Entity placed near the ray, ahead of or behind the start
   function automatic entity_type aimed_entity();
      longint k, c[3], r[3];
      k = srand(6 * ONE) + 2 * ONE;
      r[0] = $urandom_range(400, 4 * ONE);
      r[1] = $urandom_range(400, 4 * ONE);
      r[2] = r[0];
      for (int i = 0; i < 3; i++)
         c[i] = clip24(sb.org[i] + ((sb.dir[i] * k) >>> nrh_pkg::FRAC_BITS) + srand(r[i]));
      c[1] = clip24(c[1] - HALF);
      return mk(c[0], c[1], c[2], r[0], r[1], $urandom_range(0, 9) < 6, 0);
   endfunction

   function automatic entity_type random_entity();
      entity_type e;
      case ($urandom_range(0, 9))
         0, 1: begin
            e = mk(srand(8388608), srand(8388608), srand(8388608),
                   $urandom_range(0, 8388607), $urandom_range(0, 8388607),
                   $urandom_range(0, 1), 0);
         end
         2: begin
            // start inside the ellipsoid
            e = mk(clip24(sb.org[0] + srand(HALF)), clip24(sb.org[1] - HALF + srand(HALF)),
                   clip24(sb.org[2] + srand(HALF)), $urandom_range(2 * ONE, 8 * ONE),
                   $urandom_range(2 * ONE, 8 * ONE), 1, 0);
         end
         default: e = aimed_entity();
      endcase
      return e;
   endfunction

   // Directed cases, then random phases over several ray settings
   initial begin
      longint o[3], d[3];
      int items, qlen;
      entity_type e;
      sb.reset_ray();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_entity(mk(5 * ONE, -HALF, 0, ONE, ONE, 1, 1));          // plain hit
      send_entity(mk(5 * ONE, -HALF, 0, ONE, ONE, 0, 1));          // skipped
      send_entity(mk(-5 * ONE, -HALF, 0, ONE, ONE, 1, 1));         // behind, away
      send_entity(mk(5 * ONE, 10 * ONE, 0, ONE, ONE, 1, 1));       // miss
      send_entity(mk(0, -HALF, 0, 2 * ONE, 2 * ONE, 1, 1));        // inside
      send_entity(mk(3 * ONE, -HALF, 0, ONE, ONE, 1, 0));          // tie pair
      send_entity(mk(3 * ONE, -HALF, 0, ONE, ONE, 1, 0));
      send_entity(mk(0, 0, 0, 0, 0, 1, 1));                        // zero radii
      send_entity(mk(8388607, -8388608, 8388607, 8388607, 8388607, 1, 0));
      send_entity(mk(-8388608, 8388607, -8388608, 1, 1, 1, 1));
      send_entity(mk(6 * ONE, -HALF, 0, ONE, ONE, 1, 0));
      // ray change in the middle of a query
      settle();
      write_reg(nrh_pkg::CSR_ORG_X, 10 * ONE);
      write_reg(CSR_UNUSED, 24'h00ABCD);
      csr_wr_en <= 1'b0;
      send_entity(mk(12 * ONE, -HALF, 0, ONE, ONE, 1, 1));
      settle();

      items = 0;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin o = '{8388607, -8388608, 8388607}; d = '{-8388608, 8388607, 0}; end
            1: begin o = '{0, 0, 0}; d = '{0, 0, 0}; end
            2: begin o = '{-8388608, 8388607, -8388608}; d = '{8388607, -8388608, 8388607}; end
            3: begin o = '{srand(262144), srand(262144), srand(262144)}; d = '{-ONE, 0, 0}; end
            default: begin
               o = '{srand(262144), srand(262144), srand(262144)};
               d = '{srand(8192), srand(8192), srand(8192)};
            end
         endcase
         set_ray(o, d);
         if (p == 4) begin
            // index wrap: one long query, shootable entity past the wrap
            for (int i = 0; i < 260; i++) begin
               e = (i == 257) ? aimed_entity() : random_entity();
               e.shoot = (i == 257);
               e.last = (i == 259);
               send_entity(e);
            end
            items += 260;
         end
         while (items < (p + 1) * RANDOM_ITEMS / 8) begin
            qlen = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
            for (int i = 0; i < qlen; i++) begin
               e = random_entity();
               e.last = (i == qlen - 1);
               send_entity(e);
               items++;
               if (items == HOLD_AT) hold_start = 1;
               if (items >= QUIET_FROM) quiet = 1;
            end
         end
         settle();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/nrh_pkg.sv
src/nrh_div.sv
src/nrh_sqrt.sv
src/nrh_dpath.sv
src/nrh_ctrl.sv
src/nearest_ray_ellipsoid_hit_top.sv
src/nrh_checker.sv
tb/tb.sv
